FILE: hw/rtl/sktsi_pkg.sv
// ----------------------------------------------------------------------------
// sktsi_pkg
// Shared types and constants for the sorted key table search/insert block.
// ----------------------------------------------------------------------------
package sktsi_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int KEY_W               = 32;
   localparam int POS_W               = 8;
   localparam int ENTRY_COUNT_W       = 9;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef struct packed {
      action_type               action;
      logic signed [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [POS_W-1:0]           position;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } rsp_type;

   // Outcome of one probe of the binary search
   typedef struct packed {
      logic  range_open;   // lo < hi, another probe is needed
      logic  below;        // stored key below search key
      logic  equal;        // stored key equals search key
   } probe_flags_type;

endpackage

FILE: hw/rtl/sktsi_ram.sv
// ----------------------------------------------------------------------------
// sktsi_ram
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sktsi_ram #(
   parameter int DEPTH = sktsi_pkg::TABLE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [sktsi_pkg::KEY_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [sktsi_pkg::KEY_W-1:0] rd_data
);

   logic signed [sktsi_pkg::KEY_W-1:0] mem [DEPTH];
   logic signed [sktsi_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sktsi_probe.sv
// ----------------------------------------------------------------------------
// sktsi_probe
// Shared search unit: midpoint of the open range and signed key compare.
// ----------------------------------------------------------------------------
module sktsi_probe #(
   parameter int CW = 9
) (
   input  logic [CW-1:0]                      lo,
   input  logic [CW-1:0]                      hi,
   input  logic signed [sktsi_pkg::KEY_W-1:0] stored_key,
   input  logic signed [sktsi_pkg::KEY_W-1:0] search_key,
   output logic [CW-1:0]                      mid,
   output logic [CW-1:0]                      mid_plus_one,
   output sktsi_pkg::probe_flags_type         flags
);

   logic [CW-1:0] span;

   always_comb begin
      span               = hi - lo;
      mid                = lo + (span >> 1);
      mid_plus_one       = mid + CW'(1);
      flags.range_open   = (lo < hi);
      flags.below        = (stored_key < search_key);
      flags.equal        = (stored_key == search_key);
   end

endmodule

FILE: hw/rtl/sorted_key_table_search_insert_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_top
// Sorted table of signed keys with binary search, ordered insert and clear.
// ----------------------------------------------------------------------------
//
//  channel   ports                     direction  flow control
//  --------  ------------------------  ---------  -------------------------
//  request   start, busy, req_data     in         taken when start & !busy
//  result    rsp_valid, rsp_data       out        one-cycle strobe, no stall
//
//  A clear answers in the cycle after the request. Each lookup search probe
//  addresses the key store, then compares its registered read data;
//  ceil(log2(n+1)) probes for n held keys, then the result is registered.
//  An insert then moves the entries above the insertion point up one at a
//  time (the key store has one read and one write port) and writes the
//  new key in its slot.
//  Reset clears the entry count; the key store needs no clearing pass.
//  The result strobe cannot be stalled; busy is low in the cycle it shows.
//
module sorted_key_table_search_insert_top #(
   parameter int TABLE_DEPTH = sktsi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sktsi_pkg::req_type  req_data,
   output logic                rsp_valid,
   output sktsi_pkg::rsp_type  rsp_data
);

   // Address width indexes the store; count width also holds the full depth.
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = CW + sktsi_pkg::ENTRY_COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_SHIFT,
      S_DRAIN,
      S_PLACE
   } state_type;

   state_type                           state_ff, state_in;
   sktsi_pkg::action_type               action_ff, action_in;
   logic signed [sktsi_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       lo_ff, lo_in;
   logic [CW-1:0]                       hi_ff, hi_in;
   logic                                hit_ff, hit_in;
   logic [CW-1:0]                       ptr_ff, ptr_in;
   logic [AW-1:0]                       wa_ff, wa_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   sktsi_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                                ram_we;
   logic [AW-1:0]                       ram_wa;
   logic signed [sktsi_pkg::KEY_W-1:0]  ram_wd;
   logic [AW-1:0]                       ram_ra;
   logic signed [sktsi_pkg::KEY_W-1:0]  ram_rd;

   logic [CW-1:0]                       mid;
   logic [CW-1:0]                       mid_plus_one;
   sktsi_pkg::probe_flags_type          flags;
   logic [CW-1:0]                       ptr_less;
   logic [EW-1:0]                       lo_ext;
   logic [EW-1:0]                       count_ext;
   logic [EW-1:0]                       count_inc_ext;

   sktsi_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   sktsi_probe #(
      .CW (CW)
   ) u_probe (
      .lo           (lo_ff),
      .hi           (hi_ff),
      .stored_key   (ram_rd),
      .search_key   (key_ff),
      .mid          (mid),
      .mid_plus_one (mid_plus_one),
      .flags        (flags)
   );

   always_comb begin
      // Widen before narrowing to the fixed result field widths.
      ptr_less      = ptr_ff - CW'(1);
      lo_ext        = EW'(lo_ff);
      count_ext     = EW'(count_ff);
      count_inc_ext = EW'(count_ff) + EW'(1);

      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hit_in       = hit_ff;
      ptr_in       = ptr_ff;
      wa_in        = wa_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // The read port defaults to the search midpoint.
      ram_we = 1'b0;
      ram_wa = wa_ff;
      ram_wd = ram_rd;
      ram_ra = mid[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = req_data.action;
               key_in    = req_data.key;
               if (req_data.action == sktsi_pkg::ACT_CLEAR) begin
                  // Drop every entry; answer at once.
                  count_in             = '0;
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = sktsi_pkg::ST_CLEARED;
                  rsp_in.position      = '0;
                  rsp_in.entry_count   = '0;
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  hit_in   = 1'b0;
                  state_in = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            if (flags.range_open) begin
               // Midpoint read issued on the default read address.
               state_in = S_COMPARE;
            end else if (hit_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = sktsi_pkg::ST_FOUND;
               rsp_in.position    = lo_ext[sktsi_pkg::POS_W-1:0];
               rsp_in.entry_count = count_ext[sktsi_pkg::ENTRY_COUNT_W-1:0];
               state_in           = S_IDLE;
            end else if (action_ff != sktsi_pkg::ACT_INSERT) begin
               // Unused action code falls in here as a lookup.
               rsp_valid_in       = 1'b1;
               rsp_in.status      = sktsi_pkg::ST_MISS;
               rsp_in.position    = '0;
               rsp_in.entry_count = count_ext[sktsi_pkg::ENTRY_COUNT_W-1:0];
               state_in           = S_IDLE;
            end else if (count_ext == EW'(TABLE_DEPTH)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = sktsi_pkg::ST_FULL;
               rsp_in.position    = '0;
               rsp_in.entry_count = count_ext[sktsi_pkg::ENTRY_COUNT_W-1:0];
               state_in           = S_IDLE;
            end else if (lo_ff == count_ff) begin
               // New largest key: nothing to move.
               state_in = S_PLACE;
            end else begin
               ptr_in   = count_ff;
               state_in = S_SHIFT;
            end
         end

         S_COMPARE: begin
            // Narrow the range around the lower bound.
            if (flags.below) begin
               lo_in = mid_plus_one;
            end else begin
               hi_in = mid;
            end
            if (flags.equal) begin
               hit_in = 1'b1;
            end
            state_in = S_PROBE;
         end

         S_SHIFT: begin
            // Read entry ptr-1 now, write it to ptr next cycle; the previous
            // read lands in its slot this cycle except on the first pass.
            ram_ra = ptr_less[AW-1:0];
            ram_we = (ptr_ff != count_ff);
            wa_in  = ptr_ff[AW-1:0];
            ptr_in = ptr_less;
            if (ptr_less == lo_ff) begin
               state_in = S_DRAIN;
            end
         end

         S_DRAIN: begin
            ram_we   = 1'b1;
            state_in = S_PLACE;
         end

         S_PLACE: begin
            ram_we             = 1'b1;
            ram_wa             = lo_ff[AW-1:0];
            ram_wd             = key_ff;
            count_in           = count_ff + CW'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.status      = sktsi_pkg::ST_INSERTED;
            rsp_in.position    = lo_ext[sktsi_pkg::POS_W-1:0];
            rsp_in.entry_count = count_inc_ext[sktsi_pkg::ENTRY_COUNT_W-1:0];
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      hit_ff    <= hit_in;
      ptr_ff    <= ptr_in;
      wa_ff     <= wa_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
